// ===== sv/n2m_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// n2m_pkg
// Shared types, constants and saturation helper of the Newton-to-monomial
// expander.
// ----------------------------------------------------------------------------
package n2m_pkg;

  localparam int COEF_W  = 32;
  localparam int PROD_W  = 64;
  localparam int DIFF_W  = 50;
  localparam int POWER_W = 4;

  localparam logic signed [DIFF_W-1:0] SAT_HI = 50'sd2147483647;
  localparam logic signed [DIFF_W-1:0] SAT_LO = -50'sd2147483648;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUB,
    ST_ADD,
    ST_SNAP,
    ST_EMIT
  } n2m_state_t;

  typedef struct packed {
    logic mul;
    logic sub;
    logic snap;
    logic shift;
  } n2m_cell_ctrl_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] value;
    logic                     hit;
  } n2m_sat_t;

  function automatic n2m_sat_t sat32(input logic signed [DIFF_W-1:0] v);
    n2m_sat_t r;
    if (v > SAT_HI) begin
      r.value = SAT_HI[COEF_W-1:0];
      r.hit   = 1'b1;
    end else if (v < SAT_LO) begin
      r.value = SAT_LO[COEF_W-1:0];
      r.hit   = 1'b1;
    end else begin
      r.value = v[COEF_W-1:0];
      r.hit   = 1'b0;
    end
    return r;
  endfunction

endpackage

// ===== sv/n2m_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// n2m_in_if
// Input word channel: one Newton coefficient, its node and run markers.
// ----------------------------------------------------------------------------
interface n2m_in_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] coef_value;
  logic signed [31:0] node_value;
  logic        first_item;
  logic        last_item;

  modport source (output valid, coef_value, node_value, first_item, last_item,
                  input ready);
  modport sink (input valid, coef_value, node_value, first_item, last_item,
                output ready);
endinterface

// ===== sv/n2m_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// n2m_out_if
// Result word channel: one monomial coefficient with its power and flags.
// ----------------------------------------------------------------------------
interface n2m_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] mono_coef;
  logic [3:0]  power_index;
  logic        last_of_run;
  logic        saturated;

  modport source (output valid, mono_coef, power_index, last_of_run, saturated,
                  input ready);
  modport sink (input valid, mono_coef, power_index, last_of_run, saturated,
                output ready);
endinterface

// ===== sv/n2m_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// n2m_cell
// One coefficient cell: holds c[k], forms node * c[k], takes
// c[k-1] - round(node * c[k]) with saturation, and keeps a snapshot
// register that shifts toward the base cell during output.
// ----------------------------------------------------------------------------
module n2m_cell (
  input  logic                                  clk,
  input  logic                                  rst,
  input  n2m_pkg::n2m_cell_ctrl_t               ctrl,
  input  logic                                  load_en,
  input  logic signed [n2m_pkg::COEF_W-1:0]     load_val,
  input  logic signed [n2m_pkg::COEF_W-1:0]     node,
  input  logic signed [n2m_pkg::COEF_W-1:0]     lower,
  input  logic signed [n2m_pkg::COEF_W-1:0]     upper_snap,
  output logic signed [n2m_pkg::COEF_W-1:0]     coef,
  output logic signed [n2m_pkg::COEF_W-1:0]     snap,
  output logic                                  sat_hit
);

  logic signed [n2m_pkg::PROD_W-1:0] prod;
  logic signed [n2m_pkg::DIFF_W-1:0] diff;
  n2m_pkg::n2m_sat_t                 res;

  // floor((p + 2^15) / 2^16) == (p >>> 16) + p[15]
  always_comb begin
    diff = n2m_pkg::DIFF_W'(lower)
         - n2m_pkg::DIFF_W'($signed(prod[n2m_pkg::PROD_W-1:16]))
         - n2m_pkg::DIFF_W'(prod[15]);
    res  = n2m_pkg::sat32(diff);
  end

  assign sat_hit = res.hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= '0;
    end else if (load_en) begin
      coef <= load_val;
    end else if (ctrl.sub) begin
      coef <= res.value;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul) begin
      prod <= node * coef;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.snap) begin
      snap <= coef;
    end else if (ctrl.shift) begin
      snap <= upper_snap;
    end
  end

endmodule

// ===== sv/newton_to_monomial_expander.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// newton_to_monomial_expander
// Expands a Newton-form polynomial (coefficients highest term first) into
// monomial coefficients by repeated multiplication with (x - node), in a
// row of coefficient cells. Signed Q16.16 with a sticky saturation flag.
//
//   channel   role    payload
//   items     sink    coef_value, node_value, first_item, last_item
//   results   source  mono_coef, power_index, last_of_run, saturated
//
// A first word loads in its accept cycle. Any other word steps through
// accept, per-cell multiply, per-cell subtract and saturate, constant add.
// A last word adds a snapshot step, then degree + 1 result words, one
// per cycle while results.ready is high; a stalled result holds.
// No new word is taken until the last result word of a run has gone out.
// Synchronous reset clears the coefficients, degree and flag.
// ----------------------------------------------------------------------------
module newton_to_monomial_expander #(
  parameter int MAX_TERMS = 16
) (
  input  logic clk,
  input  logic rst,
  n2m_in_if.sink    items,
  n2m_out_if.source results
);

  localparam int TermCap = (MAX_TERMS < 16) ? MAX_TERMS : 16;
  localparam logic [n2m_pkg::POWER_W-1:0] DegMax = n2m_pkg::POWER_W'(TermCap - 1);

  n2m_pkg::n2m_state_t state, state_next;
  n2m_pkg::n2m_cell_ctrl_t ctrl;

  logic signed [n2m_pkg::COEF_W-1:0] coef_r;
  logic signed [n2m_pkg::COEF_W-1:0] node_r;
  logic                              last_r;
  logic [n2m_pkg::POWER_W-1:0]       degree, degree_next;
  logic [n2m_pkg::POWER_W-1:0]       idx;
  logic                              sat_flag, sat_flag_next;

  logic signed [n2m_pkg::COEF_W-1:0] coefs [TermCap];
  logic signed [n2m_pkg::COEF_W-1:0] snaps [TermCap];
  logic [TermCap-1:0]                hits;
  logic [TermCap-1:0]                load_en;
  logic signed [n2m_pkg::COEF_W-1:0] base_load;
  n2m_pkg::n2m_sat_t                 add_res;

  logic accept, load_new, out_take, cap_hit;

  assign accept   = items.valid && items.ready;
  assign load_new = accept && items.first_item;
  assign out_take = results.valid && results.ready;

  assign add_res = n2m_pkg::sat32(n2m_pkg::DIFF_W'(coefs[0]) + n2m_pkg::DIFF_W'(coef_r));
  assign cap_hit = (degree == DegMax) && (coefs[TermCap-1] != '0);
  assign base_load = (state == n2m_pkg::ST_ADD) ? add_res.value : items.coef_value;

  // coefficient cell row
  for (genvar k = 0; k < TermCap; k++) begin : g_cell
    logic signed [n2m_pkg::COEF_W-1:0] lower_w;
    logic signed [n2m_pkg::COEF_W-1:0] upper_w;
    logic signed [n2m_pkg::COEF_W-1:0] load_w;

    if (k == 0) begin : g_base
      assign lower_w    = '0;
      assign load_w     = base_load;
      assign load_en[k] = load_new || (state == n2m_pkg::ST_ADD);
    end else begin : g_body
      assign lower_w    = coefs[k-1];
      assign load_w     = '0;
      assign load_en[k] = load_new;
    end

    if (k == TermCap - 1) begin : g_top
      assign upper_w = '0;
    end else begin : g_inner
      assign upper_w = snaps[k+1];
    end

    n2m_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .load_en    (load_en[k]),
      .load_val   (load_w),
      .node       (node_r),
      .lower      (lower_w),
      .upper_snap (upper_w),
      .coef       (coefs[k]),
      .snap       (snaps[k]),
      .sat_hit    (hits[k])
    );
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      n2m_pkg::ST_IDLE: begin
        if (accept) begin
          if (!items.first_item) begin
            state_next = n2m_pkg::ST_MUL;
          end else if (items.last_item) begin
            state_next = n2m_pkg::ST_SNAP;
          end
        end
      end
      n2m_pkg::ST_MUL:  state_next = n2m_pkg::ST_SUB;
      n2m_pkg::ST_SUB:  state_next = n2m_pkg::ST_ADD;
      n2m_pkg::ST_ADD:  state_next = last_r ? n2m_pkg::ST_SNAP : n2m_pkg::ST_IDLE;
      n2m_pkg::ST_SNAP: state_next = n2m_pkg::ST_EMIT;
      n2m_pkg::ST_EMIT: begin
        if (out_take && (idx == degree)) begin
          state_next = n2m_pkg::ST_IDLE;
        end
      end
      default: state_next = n2m_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctrl          = '0;
    items.ready   = 1'b0;
    results.valid = 1'b0;
    unique case (state)
      n2m_pkg::ST_IDLE: items.ready   = 1'b1;
      n2m_pkg::ST_MUL:  ctrl.mul      = 1'b1;
      n2m_pkg::ST_SUB:  ctrl.sub      = 1'b1;
      n2m_pkg::ST_ADD:  ;
      n2m_pkg::ST_SNAP: ctrl.snap     = 1'b1;
      n2m_pkg::ST_EMIT: begin
        results.valid = 1'b1;
        ctrl.shift    = results.ready;
      end
      default: ;
    endcase
  end

  assign results.mono_coef   = snaps[0];
  assign results.power_index = idx;
  assign results.last_of_run = (idx == degree);
  assign results.saturated   = sat_flag;

  always_comb begin
    degree_next   = degree;
    sat_flag_next = sat_flag;
    if (load_new) begin
      degree_next   = '0;
      sat_flag_next = 1'b0;
    end else if (state == n2m_pkg::ST_SUB) begin
      degree_next   = (degree == DegMax) ? degree : degree + 1'b1;
      sat_flag_next = sat_flag || cap_hit || (|hits);
    end else if (state == n2m_pkg::ST_ADD) begin
      sat_flag_next = sat_flag || add_res.hit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= n2m_pkg::ST_IDLE;
      degree   <= '0;
      sat_flag <= 1'b0;
      idx      <= '0;
    end else begin
      state    <= state_next;
      degree   <= degree_next;
      sat_flag <= sat_flag_next;
      if (state == n2m_pkg::ST_SNAP) begin
        idx <= '0;
      end else if (out_take) begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      coef_r <= items.coef_value;
      node_r <= items.node_value;
      last_r <= items.last_item;
    end
  end

  // checks
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    items.ready |-> !results.valid)
    else $error("input taken while results pending");

  a_degree_cap: assert property (@(posedge clk) disable iff (rst)
    degree <= DegMax)
    else $error("degree beyond cap");

  a_step_start: assert property (@(posedge clk) disable iff (rst)
    (accept && !items.first_item) |=> (state == n2m_pkg::ST_MUL))
    else $error("step did not start multiply");

  a_power_walk: assert property (@(posedge clk) disable iff (rst)
    (out_take && !results.last_of_run) |=>
      (results.valid && (results.power_index == $past(results.power_index) + 4'd1)))
    else $error("power index did not advance");

endmodule

// ===== tb/sv/newton_to_monomial_expander_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// newton_to_monomial_expander_checker
// Watches the item and result channels of the Newton-to-monomial expander.
// Every accepted item is run through a Q16.16 expansion model; the monomial
// words it predicts are queued and compared in order, field by field, with
// the words the block hands out.
// ----------------------------------------------------------------------------
module newton_to_monomial_expander_checker #(
  parameter int MAX_TERMS = 16
) (
  input  logic clk,
  input  logic rst,
  n2m_in_if    items,
  n2m_out_if   results,
  output int   fail_count,
  output int   waiting
);

  localparam int     TERM_CAP = (MAX_TERMS < 16) ? MAX_TERMS : 16;
  localparam longint Q_MAX    = 64'sd2147483647;
  localparam longint Q_MIN    = -64'sd2147483648;

  typedef struct {
    logic signed [n2m_pkg::COEF_W-1:0]  coef;
    logic        [n2m_pkg::POWER_W-1:0] power;
    logic                               top;
    logic                               sat;
  } mono_word_t;

  mono_word_t  mono_words[$];
  longint      term[16];
  int unsigned degree;
  bit          sat_sticky;

  initial begin
    fail_count = 0;
    waiting    = 0;
  end

  function automatic void clear_poly();
    for (int k = 0; k < 16; k++) term[k] = 0;
    degree     = 0;
    sat_sticky = 1'b0;
  endfunction

  function automatic longint clip32(input longint v);
    if (v > Q_MAX) begin
      sat_sticky = 1'b1;
      return Q_MAX;
    end
    if (v < Q_MIN) begin
      sat_sticky = 1'b1;
      return Q_MIN;
    end
    return v;
  endfunction

  // round half up: floor((a * b + 2^15) / 2^16)
  function automatic longint q_product(input longint a, input longint b);
    longint p;
    p = a * b + 64'sd32768;
    return p >>> 16;
  endfunction

  function automatic void extend_by_node(input longint node);
    longint      nxt[16];
    int unsigned top;
    longint      lower;
    longint      same;
    top = degree + 1;
    if (top > TERM_CAP - 1) begin
      top = TERM_CAP - 1;
      if (term[degree] != 0) sat_sticky = 1'b1;
    end
    for (int unsigned k = 0; k <= top; k++) begin
      lower  = (k >= 1 && k - 1 <= degree) ? term[k-1] : 64'sd0;
      same   = (k <= degree) ? term[k] : 64'sd0;
      nxt[k] = clip32(lower - q_product(node, same));
    end
    for (int unsigned k = 0; k <= top; k++) term[k] = nxt[k];
    degree = top;
  endfunction

  function automatic void absorb_word(input longint coef, input longint node,
                                      input bit first, input bit last);
    mono_word_t w;
    if (first) begin
      clear_poly();
      term[0] = coef;
    end else begin
      extend_by_node(node);
      term[0] = clip32(term[0] + coef);
    end
    if (last) begin
      for (int unsigned k = 0; k <= degree; k++) begin
        w.coef  = term[k][n2m_pkg::COEF_W-1:0];
        w.power = k[n2m_pkg::POWER_W-1:0];
        w.top   = (k == degree);
        w.sat   = sat_sticky;
        mono_words.push_back(w);
      end
    end
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    if (fail_count < 100) begin
      $display("mismatch %s: got %h, expected %h", what, got, want);
    end
    fail_count++;
  endtask

  task automatic check_word();
    mono_word_t want;
    if (mono_words.size() == 0) begin
      report("unexpected word", results.mono_coef, 32'h0);
    end else begin
      want = mono_words.pop_front();
      if (results.mono_coef !== want.coef) report("mono_coef", results.mono_coef, want.coef);
      if (results.power_index !== want.power)
        report("power_index", 32'(results.power_index), 32'(want.power));
      if (results.last_of_run !== want.top)
        report("last_of_run", 32'(results.last_of_run), 32'(want.top));
      if (results.saturated !== want.sat)
        report("saturated", 32'(results.saturated), 32'(want.sat));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_poly();
      mono_words.delete();
      waiting <= 0;
    end else begin
      if (results.valid === 1'b1 && results.ready === 1'b1) check_word();
      if (items.valid === 1'b1 && items.ready === 1'b1) begin
        absorb_word(items.coef_value, items.node_value, items.first_item, items.last_item);
      end
      waiting <= mono_words.size();
    end
  end

endmodule

// ===== tb/sv/newton_to_monomial_expander_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// newton_to_monomial_expander_tb
// Drives Newton coefficient/node words into the expander: a directed set
// covering extremes, saturation, degree overflow and runs without a start
// word, then random polynomial runs with noise. Both channels stall at
// random; the checker beside the block predicts and compares the results.
// ----------------------------------------------------------------------------
module newton_to_monomial_expander_tb;

  localparam int          MAX_TERMS  = 16;
  localparam int          WORDS      = 350;
  localparam int          RUN_LIMIT  = 1000000;
  localparam int unsigned COEF_SPAN  = 32'h0020_0000;
  localparam int unsigned NODE_SPAN  = 32'h0004_0000;
  localparam logic signed [31:0] Q_ONE  = 32'sh0001_0000;
  localparam logic signed [31:0] Q_HALF = 32'sh0000_8000;
  localparam logic signed [31:0] Q_MAXV = 32'sh7fff_ffff;
  localparam logic signed [31:0] Q_MINV = 32'sh8000_0000;

  logic clk;
  logic rst;
  int   fail_count;
  int   waiting;
  int   cycle_count = 0;
  int   sent = 0;
  bit   calm_in = 1'b0;
  bit   calm_out = 1'b0;

  n2m_in_if  items();
  n2m_out_if results();

  newton_to_monomial_expander #(
    .MAX_TERMS(MAX_TERMS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .items(items),
    .results(results)
  );

  newton_to_monomial_expander_checker #(
    .MAX_TERMS(MAX_TERMS)
  ) u_expansion_check (
    .clk(clk),
    .rst(rst),
    .items(items),
    .results(results),
    .fail_count(fail_count),
    .waiting(waiting)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int draw_gap(input bit calm);
    return calm ? 0 : $urandom_range(0, 16);
  endfunction

  function automatic logic signed [31:0] pick_q(input int unsigned span);
    int v;
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 3))
          0: return Q_MAXV;
          1: return Q_MINV;
          2: return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      default: begin
        v = int'($urandom_range(0, span)) - int'(span / 2);
        return v;
      end
    endcase
  endfunction

  task automatic send_word(input logic signed [31:0] coef, input logic signed [31:0] node,
                           input logic first, input logic last);
    int n;
    n = draw_gap(calm_in);
    if (n > 0) begin
      items.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    items.valid      <= 1'b1;
    items.coef_value <= coef;
    items.node_value <= node;
    items.first_item <= first;
    items.last_item  <= last;
    do @(posedge clk); while (items.ready !== 1'b1);
    sent++;
  endtask

  task automatic drain();
    items.valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
  endtask

  // result side: random stall before each word, with calm stretches
  initial begin
    int n;
    forever begin
      if ($urandom_range(0, 23) == 0) calm_out = !calm_out;
      n = draw_gap(calm_out);
      if (n > 0) begin
        results.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      results.ready <= 1'b1;
      do @(posedge clk); while (results.valid !== 1'b1);
    end
  end

  initial begin
    int kind;
    int len;
    int next_pause;
    rst              <= 1'b1;
    items.valid      <= 1'b0;
    items.coef_value <= '0;
    items.node_value <= '0;
    items.first_item <= 1'b0;
    items.last_item  <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // no start word yet: extends the zero polynomial
    send_word(32'sh0003_0000, 32'sh0002_0000, 1'b0, 1'b1);
    // single constant terms at the extremes
    send_word(Q_MAXV, Q_MINV, 1'b1, 1'b1);
    send_word(Q_MINV, Q_MAXV, 1'b1, 1'b1);
    // constant add saturates low
    send_word(Q_ONE, 32'sd0, 1'b1, 1'b0);
    send_word(Q_MINV, Q_MAXV, 1'b0, 1'b1);
    // product saturates high, then a zero-node step adds the maximum constant
    send_word(Q_MAXV, 32'sd0, 1'b1, 1'b0);
    send_word(32'sd0, Q_MINV, 1'b0, 1'b0);
    send_word(Q_MAXV, 32'sd0, 1'b0, 1'b1);
    // degree overflow, then keep extending after the emission
    send_word(Q_ONE, 32'sd0, 1'b1, 1'b0);
    for (int i = 0; i < 16; i++) begin
      send_word(32'sh0000_4000, (i % 2) ? Q_HALF : -Q_HALF, 1'b0, i == 15);
    end
    send_word(-Q_ONE, Q_ONE, 1'b0, 1'b1);

    next_pause = sent + 120;
    while (sent < WORDS + 26) begin
      kind    = $urandom_range(0, 9);
      calm_in = ($urandom_range(0, 4) == 0);
      if (kind == 0) begin
        send_word($urandom, $urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 18) : $urandom_range(1, 6);
        for (int k = 0; k < len; k++) begin
          send_word(pick_q(COEF_SPAN), pick_q(NODE_SPAN), (k == 0) && (kind != 1),
                    (k == len - 1) || ($urandom_range(0, 15) == 0));
        end
      end
      if (sent >= next_pause) begin
        drain();
        next_pause = sent + 120;
      end
    end

    drain();
    repeat (40) @(posedge clk);
    if (fail_count == 0 && waiting == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
